// ===== sv/brc_pkg.sv =====
package brc_pkg;

   localparam int unsigned ADC_FULL     = 1048576;
   localparam int unsigned PRESS_OFFSET = 128000;
   localparam int unsigned NUM_SCALE    = 3125;
   localparam int unsigned TEMP_ROUND   = 128;
   localparam int unsigned DIV_STAGES   = 64;

   typedef enum logic [1:0] {
      CSR_TEMP_CAL   = 2'd0,
      CSR_PRESS_LO   = 2'd1,
      CSR_PRESS_HI   = 2'd2,
      CSR_PRESS_LAST = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [19:0] raw_temperature;
      logic [19:0] raw_pressure;
   } req_type;

   typedef struct packed {
      logic signed [23:0] temperature_centideg;
      logic [23:0]        pressure_pa;
      logic               pressure_invalid;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic [15:0]        p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } calib_type;

endpackage

// ===== sv/brc_temp_path.sv =====
module brc_temp_path (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [19:0]         raw_temperature,
   input  logic [19:0]         raw_pressure,
   input  brc_pkg::calib_type  cal,
   output logic                out_valid,
   output logic signed [23:0]  temperature,
   output logic signed [23:0]  temp_delta,
   output logic [19:0]         raw_pressure_out
);
   import brc_pkg::*;

   logic signed [17:0] lin_diff;
   logic signed [16:0] sq_diff;
   logic signed [33:0] lin_prod;
   logic signed [33:0] sq_prod;
   logic signed [35:0] cub_prod;
   logic signed [21:0] fine_sum;
   logic [24:0]        t5;

   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic [31:0] a1_ff, dsq1_ff, m2_ff;
   logic [20:0] v1t2_ff;
   logic [21:0] tf3_ff;
   logic [19:0] rp1_ff, rp2_ff, rp3_ff, rp4_ff;
   logic [23:0] temp4_ff, e4_ff;

   // stage 1: offset against T1, then the two first products
   always_comb begin
      lin_diff = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
      sq_diff  = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, cal.t1});
      lin_prod = lin_diff * cal.t2;
      sq_prod  = sq_diff * sq_diff;
      cub_prod = $signed(dsq1_ff[31:12]) * cal.t3;
      fine_sum = $signed({v1t2_ff[20], v1t2_ff}) + $signed({{4{m2_ff[31]}}, m2_ff[31:14]});
      t5       = {{3{tf3_ff[21]}}, tf3_ff} + {tf3_ff[21], tf3_ff, 2'b00} + 25'(TEMP_ROUND);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff    <= lin_prod[31:0];
         dsq1_ff  <= sq_prod[31:0];
         rp1_ff   <= raw_pressure;
         v1t2_ff  <= a1_ff[31:11];
         m2_ff    <= cub_prod[31:0];
         rp2_ff   <= rp1_ff;
         tf3_ff   <= fine_sum;
         rp3_ff   <= rp2_ff;
         temp4_ff <= {{7{t5[24]}}, t5[24:8]};
         e4_ff    <= {{2{tf3_ff[21]}}, tf3_ff} - 24'(PRESS_OFFSET);
         rp4_ff   <= rp3_ff;
      end
   end

   assign out_valid        = v4_ff;
   assign temperature      = $signed(temp4_ff);
   assign temp_delta       = $signed(e4_ff);
   assign raw_pressure_out = rp4_ff;

endmodule

// ===== sv/brc_press_coeff.sv =====
module brc_press_coeff (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic signed [23:0]  temperature,
   input  logic signed [23:0]  temp_delta,
   input  logic [19:0]         raw_pressure,
   input  brc_pkg::calib_type  cal,
   output logic                out_valid,
   output logic signed [23:0]  temperature_out,
   output logic [63:0]         numerator,
   output logic [30:0]         divisor
);
   import brc_pkg::*;

   logic signed [47:0] ee_prod;
   logic signed [39:0] ep5_prod, ep2_prod;
   logic signed [63:0] eep6_prod, eep3_prod;
   logic [63:0]        x2_sum;
   logic [55:0]        x1_sum;
   logic [20:0]        gap;
   logic [43:0]        x1_lo_prod;
   logic signed [44:0] x1_hi_prod;
   logic [63:0]        x1_full;
   logic [43:0]        n_lo_prod;
   logic [31:0]        n_hi_prod;

   logic        v_ff [6];
   logic [23:0] temp_ff [6];
   logic [19:0] rp5_ff, rp6_ff, rp7_ff;
   logic [47:0] ee5_ff;
   logic [39:0] ep5_5_ff, ep2_5_ff, ep5_6_ff, ep2_6_ff;
   logic [63:0] eep6_6_ff, eep3_6_ff;
   logic [63:0] x2_7_ff;
   logic [55:0] x1_7_ff;
   logic [43:0] x1lo8_ff;
   logic [35:0] x1hi8_ff;
   logic [63:0] nb8_ff;
   logic [30:0] div9_ff, div10_ff;
   logic [43:0] nlo9_ff;
   logic [31:0] nhi9_ff;
   logic [63:0] num10_ff;

   always_comb begin
      ee_prod   = temp_delta * temp_delta;
      ep5_prod  = temp_delta * cal.p5;
      ep2_prod  = temp_delta * cal.p2;
      eep6_prod = $signed(ee5_ff) * cal.p6;
      eep3_prod = $signed(ee5_ff) * cal.p3;
      x2_sum    = eep6_6_ff
                + ({{24{ep5_6_ff[39]}}, ep5_6_ff} << 17)
                + {{13{cal.p4[15]}}, cal.p4, 35'd0};
      x1_sum    = eep3_6_ff[63:8]
                + {{4{ep2_6_ff[39]}}, ep2_6_ff, 12'd0}
                + (56'd1 << 47);
      gap        = 21'(ADC_FULL) - {1'b0, rp7_ff};
      x1_lo_prod = x1_7_ff[27:0] * cal.p1;
      x1_hi_prod = $signed(x1_7_ff[55:28]) * $signed({1'b0, cal.p1});
      x1_full    = {20'd0, x1lo8_ff} + {x1hi8_ff, 28'd0};
      n_lo_prod  = nb8_ff[31:0] * 12'(NUM_SCALE);
      n_hi_prod  = nb8_ff[63:32] * 32'(NUM_SCALE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '{default: 1'b0};
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int k = 1; k < 6; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         temp_ff[0] <= temperature;
         for (int k = 1; k < 6; k++) begin
            temp_ff[k] <= temp_ff[k-1];
         end
         // stage 5: square and linear terms of the temperature offset
         ee5_ff    <= ee_prod;
         ep5_5_ff  <= ep5_prod;
         ep2_5_ff  <= ep2_prod;
         rp5_ff    <= raw_pressure;
         // stage 6: scale the square term
         eep6_6_ff <= eep6_prod;
         eep3_6_ff <= eep3_prod;
         ep5_6_ff  <= ep5_5_ff;
         ep2_6_ff  <= ep2_5_ff;
         rp6_ff    <= rp5_ff;
         // stage 7: collect both polynomials
         x2_7_ff   <= x2_sum;
         x1_7_ff   <= x1_sum;
         rp7_ff    <= rp6_ff;
         // stage 8: split product with P1, raw numerator
         x1lo8_ff  <= x1_lo_prod;
         x1hi8_ff  <= x1_hi_prod[35:0];
         nb8_ff    <= {12'd0, gap, 31'd0} - x2_7_ff;
         // stage 9: divisor done, split product with the scale
         div9_ff   <= x1_full[63:33];
         nlo9_ff   <= n_lo_prod;
         nhi9_ff   <= n_hi_prod;
         // stage 10: numerator done
         num10_ff  <= {20'd0, nlo9_ff} + {nhi9_ff, 32'd0};
         div10_ff  <= div9_ff;
      end
   end

   assign out_valid       = v_ff[5];
   assign temperature_out = $signed(temp_ff[5]);
   assign numerator       = num10_ff;
   assign divisor         = div10_ff;

endmodule

// ===== sv/brc_divider.sv =====
module brc_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [23:0] temperature,
   input  logic [63:0]        numerator,
   input  logic [30:0]        divisor,
   output logic               out_valid,
   output logic signed [23:0] temperature_out,
   output logic               invalid,
   output logic [63:0]        quotient
);
   import brc_pkg::*;

   logic        vld_ff  [DIV_STAGES+1];
   logic [30:0] rem_ff  [DIV_STAGES+1];
   logic [63:0] nq_ff   [DIV_STAGES+1];
   logic [30:0] md_ff   [DIV_STAGES+1];
   logic        qneg_ff [DIV_STAGES+1];
   logic        inv_ff  [DIV_STAGES+1];
   logic [23:0] temp_ff [DIV_STAGES+1];

   logic [30:0] rem_in [DIV_STAGES+1];
   logic [63:0] nq_in  [DIV_STAGES+1];

   logic        fix_vld_ff;
   logic        fix_inv_ff;
   logic [23:0] fix_temp_ff;
   logic [63:0] fix_q_ff;

   // one quotient bit per stage; numerator bits shift out the top while
   // quotient bits shift in at the bottom
   always_comb begin
      logic [31:0] trial;
      logic [31:0] diff;
      rem_in[0] = '0;
      nq_in[0]  = numerator[63] ? (64'd0 - numerator) : numerator;
      for (int k = 1; k <= DIV_STAGES; k++) begin
         trial = {rem_ff[k-1], nq_ff[k-1][63]};
         diff  = trial - {1'b0, md_ff[k-1]};
         if (trial >= {1'b0, md_ff[k-1]}) begin
            rem_in[k] = diff[30:0];
            nq_in[k]  = {nq_ff[k-1][62:0], 1'b1};
         end else begin
            rem_in[k] = trial[30:0];
            nq_in[k]  = {nq_ff[k-1][62:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '{default: 1'b0};
         fix_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k <= DIV_STAGES; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         fix_vld_ff <= vld_ff[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= rem_in[0];
         nq_ff[0]   <= nq_in[0];
         md_ff[0]   <= divisor[30] ? (31'd0 - divisor) : divisor;
         qneg_ff[0] <= numerator[63] ^ divisor[30];
         inv_ff[0]  <= (divisor == 31'd0);
         temp_ff[0] <= temperature;
         for (int k = 1; k <= DIV_STAGES; k++) begin
            rem_ff[k]  <= rem_in[k];
            nq_ff[k]   <= nq_in[k];
            md_ff[k]   <= md_ff[k-1];
            qneg_ff[k] <= qneg_ff[k-1];
            inv_ff[k]  <= inv_ff[k-1];
            temp_ff[k] <= temp_ff[k-1];
         end
         fix_q_ff    <= qneg_ff[DIV_STAGES] ? (64'd0 - nq_ff[DIV_STAGES]) : nq_ff[DIV_STAGES];
         fix_inv_ff  <= inv_ff[DIV_STAGES];
         fix_temp_ff <= temp_ff[DIV_STAGES];
      end
   end

   assign out_valid       = fix_vld_ff;
   assign temperature_out = $signed(fix_temp_ff);
   assign invalid         = fix_inv_ff;
   assign quotient        = fix_q_ff;

   a_rem_below_divisor : assert property (@(posedge clock) disable iff (reset)
      (vld_ff[DIV_STAGES] && md_ff[DIV_STAGES] != 31'd0)
         |-> (rem_ff[DIV_STAGES] < md_ff[DIV_STAGES]))
      else $error("divider remainder not below divisor");

   a_hold_on_stall : assert property (@(posedge clock) disable iff (reset)
      (!en && fix_vld_ff) |=> (fix_vld_ff && $stable(fix_q_ff)))
      else $error("divider output changed during stall");

endmodule

// ===== sv/brc_press_final.sv =====
module brc_press_final (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [23:0] temperature,
   input  logic               invalid,
   input  logic [63:0]        quotient,
   input  brc_pkg::calib_type cal,
   output logic               out_valid,
   output brc_pkg::rsp_type   result
);
   import brc_pkg::*;

   logic signed [63:0] ps;
   logic [63:0]        sll_prod;
   logic [31:0]        slh_prod;
   logic signed [48:0] p8l_prod;
   logic signed [31:0] p8h_prod;
   logic [63:0]        sq_sum;
   logic [63:0]        y2_sum;
   logic signed [48:0] al_prod;
   logic signed [31:0] ah_prod;
   logic [63:0]        y1_sum;
   logic [31:0]        tail_sum;

   logic        v_ff [6];
   logic [23:0] temp_ff [6];
   logic        inv_ff [6];
   logic [63:0] p_ff [4];
   logic [63:0] sll2_ff;
   logic [30:0] slh2_ff;
   logic [48:0] p8l2_ff;
   logic [31:0] p8h2_ff;
   logic [63:0] sq3_ff;
   logic [44:0] y2_ff [3];
   logic [48:0] al4_ff;
   logic [31:0] ah4_ff;
   logic [38:0] y1_5_ff;
   logic [63:0] s6_ff;
   logic [23:0] pres7_ff;

   always_comb begin
      ps       = $signed(quotient) >>> 13;
      sll_prod = ps[31:0] * ps[31:0];
      slh_prod = ps[31:0] * ps[63:32];
      p8l_prod = $signed({1'b0, quotient[31:0]}) * cal.p8;
      p8h_prod = $signed(quotient[63:32]) * cal.p8;
      // square mod 2^64: low product plus twice the cross term, one word up
      sq_sum   = sll2_ff + {slh2_ff, 33'd0};
      y2_sum   = {{15{p8l2_ff[48]}}, p8l2_ff} + {p8h2_ff, 32'd0};
      al_prod  = $signed({1'b0, sq3_ff[31:0]}) * cal.p9;
      ah_prod  = $signed(sq3_ff[63:32]) * cal.p9;
      y1_sum   = {{15{al4_ff[48]}}, al4_ff} + {ah4_ff, 32'd0};
      tail_sum = s6_ff[39:8] + {{12{cal.p7[15]}}, cal.p7, 4'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '{default: 1'b0};
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int k = 1; k < 6; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         temp_ff[0] <= temperature;
         inv_ff[0]  <= invalid;
         for (int k = 1; k < 6; k++) begin
            temp_ff[k] <= temp_ff[k-1];
            inv_ff[k]  <= inv_ff[k-1];
         end
         p_ff[0] <= quotient;
         for (int k = 1; k < 4; k++) begin
            p_ff[k] <= p_ff[k-1];
         end
         sll2_ff  <= sll_prod;
         slh2_ff  <= slh_prod[30:0];
         p8l2_ff  <= p8l_prod;
         p8h2_ff  <= p8h_prod;
         sq3_ff   <= sq_sum;
         y2_ff[0] <= y2_sum[63:19];
         y2_ff[1] <= y2_ff[0];
         y2_ff[2] <= y2_ff[1];
         al4_ff   <= al_prod;
         ah4_ff   <= ah_prod;
         y1_5_ff  <= y1_sum[63:25];
         s6_ff    <= p_ff[3] + {{25{y1_5_ff[38]}}, y1_5_ff} + {{19{y2_ff[2][44]}}, y2_ff[2]};
         pres7_ff <= inv_ff[4] ? 24'd0 : tail_sum[31:8];
      end
   end

   assign out_valid                   = v_ff[5];
   assign result.temperature_centideg = $signed(temp_ff[5]);
   assign result.pressure_pa          = pres7_ff;
   assign result.pressure_invalid     = inv_ff[5];

endmodule

// ===== sv/barometer_reading_compensation.sv =====
// Compensates one pair of raw 20-bit converter readings per transaction:
// the result carries the temperature in hundredths of a degree Celsius and
// the pressure in whole pascals, plus a flag that marks a zero pressure
// divisor (pressure then reads 0, the temperature is still valid). A new
// transaction is taken every clock while the pipeline advances. The path
// holds 83 register stages: the 64-stage pressure divider (one quotient
// bit per stage) together with four temperature stages, six polynomial
// stages, divider setup and sign stages, six final pressure stages and
// the result register. The pipeline advances whenever its last stage or
// the result register is free, so a waiting result blocks new requests only
// once the last stage holds a transaction as well. Write the calibration
// registers only while nothing is in flight; they reset to zero.
module barometer_reading_compensation (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  brc_pkg::req_type      req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output brc_pkg::rsp_type      rsp_data,
   input  logic                  csr_we,
   input  brc_pkg::csr_idx_type  csr_index,
   input  logic [63:0]           csr_wdata
);
   import brc_pkg::*;

   logic [47:0] temp_cal_ff;
   logic [63:0] press_lo_ff;
   logic [63:0] press_hi_ff;
   logic [15:0] press_last_ff;
   calib_type   cal;

   logic        advance;

   logic               tp_valid;
   logic signed [23:0] tp_temp;
   logic signed [23:0] tp_delta;
   logic [19:0]        tp_rawp;

   logic               pc_valid;
   logic signed [23:0] pc_temp;
   logic [63:0]        pc_num;
   logic [30:0]        pc_div;

   logic               dv_valid;
   logic signed [23:0] dv_temp;
   logic               dv_invalid;
   logic [63:0]        dv_quot;

   logic               fin_valid;
   rsp_type            fin_result;

   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;
   logic               out_free;

   // calibration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff   <= '0;
         press_lo_ff   <= '0;
         press_hi_ff   <= '0;
         press_last_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TEMP_CAL:   temp_cal_ff   <= csr_wdata[47:0];
            CSR_PRESS_LO:   press_lo_ff   <= csr_wdata;
            CSR_PRESS_HI:   press_hi_ff   <= csr_wdata;
            CSR_PRESS_LAST: press_last_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // unpack the calibration words, lowest word first in each register
   always_comb begin
      cal.t1 = temp_cal_ff[15:0];
      cal.t2 = $signed(temp_cal_ff[31:16]);
      cal.t3 = $signed(temp_cal_ff[47:32]);
      cal.p1 = press_lo_ff[15:0];
      cal.p2 = $signed(press_lo_ff[31:16]);
      cal.p3 = $signed(press_lo_ff[47:32]);
      cal.p4 = $signed(press_lo_ff[63:48]);
      cal.p5 = $signed(press_hi_ff[15:0]);
      cal.p6 = $signed(press_hi_ff[31:16]);
      cal.p7 = $signed(press_hi_ff[47:32]);
      cal.p8 = $signed(press_hi_ff[63:48]);
      cal.p9 = $signed(press_last_ff);
   end

   // The result register takes a new transaction when empty or being
   // drained; the whole pipeline moves when its last stage is empty or can
   // drop into the result register. Only a full last stage behind a full,
   // stalled result register holds everything.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = !fin_valid || out_free;
   assign req_ready = advance;

   brc_temp_path u_temp (
      .clock            (clock),
      .reset            (reset),
      .en               (advance),
      .in_valid         (req_valid),
      .raw_temperature  (req_data.raw_temperature),
      .raw_pressure     (req_data.raw_pressure),
      .cal              (cal),
      .out_valid        (tp_valid),
      .temperature      (tp_temp),
      .temp_delta       (tp_delta),
      .raw_pressure_out (tp_rawp)
   );

   brc_press_coeff u_coeff (
      .clock           (clock),
      .reset           (reset),
      .en              (advance),
      .in_valid        (tp_valid),
      .temperature     (tp_temp),
      .temp_delta      (tp_delta),
      .raw_pressure    (tp_rawp),
      .cal             (cal),
      .out_valid       (pc_valid),
      .temperature_out (pc_temp),
      .numerator       (pc_num),
      .divisor         (pc_div)
   );

   brc_divider u_div (
      .clock           (clock),
      .reset           (reset),
      .en              (advance),
      .in_valid        (pc_valid),
      .temperature     (pc_temp),
      .numerator       (pc_num),
      .divisor         (pc_div),
      .out_valid       (dv_valid),
      .temperature_out (dv_temp),
      .invalid         (dv_invalid),
      .quotient        (dv_quot)
   );

   brc_press_final u_final (
      .clock       (clock),
      .reset       (reset),
      .en          (advance),
      .in_valid    (dv_valid),
      .temperature (dv_temp),
      .invalid     (dv_invalid),
      .quotient    (dv_quot),
      .cal         (cal),
      .out_valid   (fin_valid),
      .result      (fin_result)
   );

   // result register: hold while the consumer stalls, else take the last stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= fin_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_data_ff <= fin_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.pressure_invalid) |-> (rsp_data.pressure_pa == 24'd0))
      else $error("invalid pressure result not forced to zero");

   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty result register");

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready && fin_valid))
      else $error("pipeline stalled without a blocked result");

endmodule
